// File: sv/assert_macros.svh
// Assertion macros used by the top-level file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: sv/bpsr_pkg.sv
// Package for the byte pattern search and replace block: types, constants, helpers.
`default_nettype none
package bpsr_pkg;

    localparam int MAX_PATTERN = 24;
    localparam int FILL_W      = 5;
    localparam int CNT_W       = 24;
    localparam int MAXR_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBST_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBST_MID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBST_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPLACES = 3'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             from_subst;
        logic             out_last;
        logic [CNT_W-1:0] match_count;
    } t_out;

    // One command from the front: either a single window byte or a whole
    // replacement burst, which the back expands from the replacement registers.
    typedef struct packed {
        logic             is_burst;
        logic [7:0]       data;
        logic             last;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic [MAX_PATTERN*8-1:0] pattern;
        logic [MAX_PATTERN*8-1:0] subst;
        logic [FILL_W-1:0]        len;
        logic [MAXR_W-1:0]        max_replaces;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // Length as used by the datapath: zero acts as one, oversize as the maximum.
    function automatic logic [FILL_W-1:0] active_len(input logic [FILL_W-1:0] raw);
        logic [FILL_W-1:0] len;
        len = raw;
        if (raw == '0) begin
            len = FILL_W'(1);
        end else if (raw > FILL_W'(MAX_PATTERN)) begin
            len = FILL_W'(MAX_PATTERN);
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// File: sv/bpsr_front.sv
// Front end: holds the sliding window, matches it against the pattern and issues commands.
`default_nettype none
module bpsr_front
    import bpsr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [7:0]        r_win [MAX_PATTERN];
    logic [7:0]        n_win [MAX_PATTERN];
    logic [7:0]        e_win [MAX_PATTERN];
    logic [FILL_W-1:0] r_fill, n_fill, e_fill;
    logic [CNT_W-1:0]  r_cnt, n_cnt, cnt_inc;
    logic              r_pend, n_pend;
    logic              r_chk, n_chk, e_chk;
    logic              r_last, e_last;

    logic accept, go, match, allowed, act_pop, act_burst, cmd_last, more;

    assign o_in_ready = !r_pend && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign go         = accept || (r_pend && !i_q_full);

    // The accepted word joins the window in the same cycle as the first action on it.
    always_comb begin
        e_fill = accept ? r_fill + FILL_W'(1) : r_fill;
        e_chk  = accept ? 1'b0 : r_chk;
        e_last = accept ? i_in_data.in_last : r_last;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            e_win[i] = (accept && r_fill == FILL_W'(i)) ? i_in_data.in_byte : r_win[i];
        end
    end

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (FILL_W'(i) < i_cfg.len && e_win[i] != i_cfg.pattern[i*8 +: 8]) begin
                match = 1'b0;
            end
        end
    end

    assign allowed = (i_cfg.max_replaces == '0) ||
                     (r_cnt < {{(CNT_W-MAXR_W){1'b0}}, i_cfg.max_replaces});
    assign cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);

    always_comb begin
        act_pop   = 1'b0;
        act_burst = 1'b0;
        cmd_last  = 1'b0;
        n_fill    = e_fill;
        n_chk     = e_chk;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        more      = 1'b0;
        if (go) begin
            if (e_fill > i_cfg.len) begin
                // Window longer than the pattern after a length change.
                act_pop = 1'b1;
            end else if (e_fill == i_cfg.len && !e_chk) begin
                n_chk = 1'b1;
                if (match && allowed) begin
                    act_burst = 1'b1;
                    n_fill    = '0;
                    n_cnt     = cnt_inc;
                    cmd_last  = e_last;
                end else begin
                    act_pop  = 1'b1;
                    cmd_last = e_last && (e_fill == FILL_W'(1));
                end
            end else if (e_last && e_fill != '0) begin
                act_pop  = 1'b1;
                cmd_last = (e_fill == FILL_W'(1));
            end
            if (act_pop) begin
                n_fill = e_fill - FILL_W'(1);
            end
            more = (n_fill > i_cfg.len) || (n_fill == i_cfg.len && !n_chk) ||
                   (e_last && n_fill != '0);
            n_pend = more;
            if (!more && e_last) begin
                n_cnt  = '0;
                n_fill = '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (act_pop && i < MAX_PATTERN - 1) begin
                n_win[i] = e_win[i+1];
            end else begin
                n_win[i] = e_win[i];
            end
        end
    end

    always_comb begin
        o_push         = act_pop || act_burst;
        o_cmd.is_burst = act_burst;
        o_cmd.data     = e_win[0];
        o_cmd.last     = cmd_last;
        o_cmd.count    = act_burst ? cnt_inc : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (accept) begin
            r_last <= i_in_data.in_last;
        end
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_chk  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
            r_chk  <= n_chk;
        end
    end

endmodule
`default_nettype wire

// File: sv/bpsr_queue.sv
// Short command queue between the front and back ends.
`default_nettype none
module bpsr_queue
    import bpsr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_qstat    o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_head      = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/bpsr_back.sv
// Back end: expands queued commands into output words through the output register.
`default_nettype none
module bpsr_back
    import bpsr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_head,
    input  wire logic i_q_empty,
    output logic      o_pop,
    input  wire t_cfg i_cfg,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic              r_valid;
    t_out              r_out, n_out;
    logic [FILL_W-1:0] r_idx;
    logic              load, last_beat;

    assign load      = !i_q_empty && (!r_valid || i_out_ready);
    assign last_beat = !i_head.is_burst || (r_idx == i_cfg.len - FILL_W'(1));
    assign o_pop     = load && last_beat;

    always_comb begin
        n_out.match_count = i_head.count;
        if (i_head.is_burst) begin
            n_out.out_byte   = i_cfg.subst[{r_idx, 3'b000} +: 8];
            n_out.from_subst = 1'b1;
            n_out.out_last   = i_head.last && last_beat;
        end else begin
            n_out.out_byte   = i_head.data;
            n_out.from_subst = 1'b0;
            n_out.out_last   = i_head.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_beat ? '0 : r_idx + FILL_W'(1);
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/byte_pattern_search_replace.sv
// Path: an accepted word's command is written into the queue, then into the output register.
// Throughput: one input word and one output word per cycle while the queue is not full and
// the output is ready. Window actions (a pop or a pattern check) are issued one at a time,
// so a stream end or a length reduction stalls the input until they are done; a replacement
// of L bytes holds the output side for L words, absorbed by a four-entry queue.
// Reset: synchronous, clears control state and configuration; window bytes are not cleared.
`default_nettype none
`include "assert_macros.svh"
module byte_pattern_search_replace
    import bpsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    logic [MAX_PATTERN*8-1:0] r_pattern, r_subst;
    logic [FILL_W-1:0]        r_len;
    logic [MAXR_W-1:0]        r_max;
    t_cfg                     cfg;

    logic   q_push, q_pop;
    t_cmd   q_cmd, q_head;
    t_qstat q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_subst   <= '0;
            r_len     <= FILL_W'(1);
            r_max     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pattern[63:0]    <= i_cfg_data;
                CFG_PATTERN_MID:  r_pattern[127:64]  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pattern[191:128] <= i_cfg_data;
                CFG_SUBST_LOW:    r_subst[63:0]      <= i_cfg_data;
                CFG_SUBST_MID:    r_subst[127:64]    <= i_cfg_data;
                CFG_SUBST_HIGH:   r_subst[191:128]   <= i_cfg_data;
                CFG_PATTERN_LEN:  r_len              <= i_cfg_data[FILL_W-1:0];
                CFG_MAX_REPLACES: r_max              <= i_cfg_data[MAXR_W-1:0];
                default:          r_max              <= r_max;
            endcase
        end
    end

    always_comb begin
        cfg.pattern      = r_pattern;
        cfg.subst        = r_subst;
        cfg.len          = active_len(r_len);
        cfg.max_replaces = r_max;
    end

    bpsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_q_full   (q_stat.full),
        .o_push     (q_push),
        .o_cmd      (q_cmd)
    );

    bpsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bpsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_empty   (q_stat.empty),
        .o_pop       (q_pop),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The front must never issue a command into a full queue.
    `ASSERT_NEVER(a_no_overflow, q_push && q_stat.full, "command pushed into full queue")
    // The back must never take a command from an empty queue.
    `ASSERT_NEVER(a_no_underflow, q_pop && q_stat.empty, "command popped from empty queue")
    // A word is only accepted when the queue can take the action it causes.
    `ASSERT_ALWAYS(a_accept_space, (i_in_valid && o_in_ready) |-> !q_stat.full,
                   "input word accepted with queue full")

endmodule
`default_nettype wire
